// ===== hw/rtl/quadtree_face_neighbor_finder_defines.svh =====
// ----------------------------------------------------------------------------
// Quadtree face neighbour finder: assertion macros
// Shared property forms for the concurrent checks of the finder.
// ----------------------------------------------------------------------------
`ifndef QUADTREE_FACE_NEIGHBOR_FINDER_DEFINES_SVH
`define QUADTREE_FACE_NEIGHBOR_FINDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define QNF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quadtree finder check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define QNF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quadtree finder check failed");

`endif

// ===== hw/rtl/qnf_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadtree face neighbour finder package
// Transaction types, cell address type and direction tables.
// ----------------------------------------------------------------------------
package qnf_pkg;

  localparam int LVL_W = 3;
  localparam int CRD_W = 7;

  // Step of the neighbour cell, indexed by direction.
  localparam logic signed [1:0] STEP_DR [4] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0};
  localparam logic signed [1:0] STEP_DC [4] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1};

  // Child offsets of the two corners that touch the shared face, one bit per
  // direction (bit n belongs to direction n).
  localparam logic [3:0] NEAR_A_R = 4'b0010;
  localparam logic [3:0] NEAR_A_C = 4'b1000;
  localparam logic [3:0] NEAR_B_R = 4'b1110;
  localparam logic [3:0] NEAR_B_C = 4'b1011;

  // Item function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic             func;
    logic [LVL_W-1:0] cell_level;
    logic [CRD_W-1:0] cell_row;
    logic [CRD_W-1:0] cell_col;
    logic [1:0]       direction;
    logic [LVL_W-1:0] target_level;
    logic             used_value;
  } qnf_in_t;

  typedef struct packed {
    logic [LVL_W-1:0] found_level;
    logic [CRD_W-1:0] first_row;
    logic [CRD_W-1:0] first_col;
    logic             second_valid;
    logic [CRD_W-1:0] second_row;
    logic [CRD_W-1:0] second_col;
    logic             request_error;
  } qnf_out_t;

  // One cell of the pyramid, as presented to the address unit.
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] col;
  } qnf_cell_t;

endpackage

// ===== hw/rtl/qnf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qnf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/qnf_addr.sv =====
// ----------------------------------------------------------------------------
// Quadtree face neighbour finder: address unit
// Maps a level, row and column to the flat index of the used-bit pyramid.
// ----------------------------------------------------------------------------
module qnf_addr #(
  parameter int AW = 15
) (
  input  qnf_pkg::qnf_cell_t loc,
  output logic [AW-1:0]      addr
);
  import qnf_pkg::*;

  logic [15:0] base;
  logic [15:0] offset;
  logic [15:0] sum;

  // The first index of level n is (4^n - 1) / 3, i.e. binary 0101...01 with
  // n ones on the even bit positions.
  always_comb begin
    base = '0;
    for (int i = 0; i < 7; i++) begin
      base[2*i] = (LVL_W'(i) < loc.lvl);
    end
  end

  // Column is below 2^lvl, so it fills the low bits left free by the shift.
  assign offset = (16'(loc.row) << loc.lvl) | 16'(loc.col);
  assign sum    = base + offset;
  assign addr   = AW'(sum);

endmodule

// ===== hw/rtl/qnf_walker.sv =====
// ----------------------------------------------------------------------------
// Quadtree face neighbour finder: query sequencer
// Walks up or down the pyramid, one used-bit probe per cycle.
// ----------------------------------------------------------------------------
module qnf_walker #(
  parameter int LEVELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  qnf_pkg::qnf_in_t   item,
  input  logic               used_bit,
  output qnf_pkg::qnf_cell_t probe,
  output logic               busy,
  output logic               res_strobe,
  output qnf_pkg::qnf_out_t  res
);
  import qnf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_CLIMB  = 3'd2;
  localparam logic [2:0] S_PAIR_A = 3'd3;
  localparam logic [2:0] S_PAIR_B = 3'd4;
  localparam logic [2:0] S_SING_A = 3'd5;
  localparam logic [2:0] S_SING_B = 3'd6;

  logic [2:0]       state_r,  state_nxt;
  logic             strobe_r, strobe_nxt;
  qnf_out_t         res_r,    res_nxt;
  logic [LVL_W-1:0] d_r,      d_nxt;
  logic [LVL_W-1:0] tl_r,     tl_nxt;
  logic [CRD_W-1:0] row_r,    row_nxt;
  logic [CRD_W-1:0] col_r,    col_nxt;
  logic [1:0]       dir_r,    dir_nxt;
  logic [LVL_W-1:0] lvl_r,    lvl_nxt;
  logic [CRD_W-1:0] ar_r,     ar_nxt;
  logic [CRD_W-1:0] ac_r,     ac_nxt;
  logic [CRD_W-1:0] br_r,     br_nxt;
  logic [CRD_W-1:0] bc_r,     bc_nxt;
  logic             a_used_r, a_used_nxt;

  logic [LVL_W-1:0] tl_eff;
  logic [7:0]       size;
  logic [7:0]       nr;
  logic [7:0]       nc;
  logic             bad_item;
  logic             off_grid;
  logic             deeper;
  logic             sel_b;
  logic [CRD_W-1:0] pa_row, pa_col, pb_row, pb_col;

  function automatic qnf_out_t mk_res(input logic [LVL_W-1:0] lvl,
                                      input logic [CRD_W-1:0] r1,
                                      input logic [CRD_W-1:0] c1,
                                      input logic             two,
                                      input logic [CRD_W-1:0] r2,
                                      input logic [CRD_W-1:0] c2);
    qnf_out_t o;
    o.found_level   = lvl;
    o.first_row     = r1;
    o.first_col     = c1;
    o.second_valid  = two;
    o.second_row    = two ? r2 : '0;
    o.second_col    = two ? c2 : '0;
    o.request_error = 1'b0;
    return o;
  endfunction

  function automatic qnf_out_t err_res();
    qnf_out_t o;
    o               = '0;
    o.request_error = 1'b1;
    return o;
  endfunction

  // A target level beyond the pyramid saturates to its finest level.
  assign tl_eff = (32'(tl_r) >= LEVELS) ? LVL_W'(LEVELS - 1) : tl_r;
  assign size   = 8'd1 << d_r;
  assign nr     = {1'b0, row_r} + {{6{STEP_DR[dir_r][1]}}, STEP_DR[dir_r]};
  assign nc     = {1'b0, col_r} + {{6{STEP_DC[dir_r][1]}}, STEP_DC[dir_r]};
  // A step below zero wraps to all ones, which is never inside the level.
  assign off_grid = (nr >= size) || (nc >= size);
  assign bad_item = (32'(d_r) >= LEVELS) || ({1'b0, row_r} >= size) ||
                    ({1'b0, col_r} >= size) || (tl_eff < d_r);
  assign deeper   = (lvl_r < tl_eff);

  assign pa_row = {1'b0, ar_r[CRD_W-1:1]};
  assign pa_col = {1'b0, ac_r[CRD_W-1:1]};
  assign pb_row = {1'b0, br_r[CRD_W-1:1]};
  assign pb_col = {1'b0, bc_r[CRD_W-1:1]};

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    d_nxt      = d_r;
    tl_nxt     = tl_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    dir_nxt    = dir_r;
    lvl_nxt    = lvl_r;
    ar_nxt     = ar_r;
    ac_nxt     = ac_r;
    br_nxt     = br_r;
    bc_nxt     = bc_r;
    a_used_nxt = a_used_r;

    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          d_nxt     = item.cell_level;
          tl_nxt    = item.target_level;
          row_nxt   = item.cell_row;
          col_nxt   = item.cell_col;
          dir_nxt   = item.direction;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (bad_item) begin
          res_nxt    = err_res();
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else if (off_grid) begin
          res_nxt    = mk_res(d_r, row_r, col_r, 1'b0, '0, '0);
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          lvl_nxt   = d_r;
          ar_nxt    = nr[CRD_W-1:0];
          ac_nxt    = nc[CRD_W-1:0];
          state_nxt = S_CLIMB;
        end
      end

      // Probe of the neighbour cell and then of its ancestors.
      S_CLIMB: begin
        if (used_bit) begin
          if (lvl_r != d_r || d_r == tl_eff) begin
            res_nxt    = mk_res(lvl_r, ar_r, ac_r, 1'b0, '0, '0);
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            lvl_nxt   = lvl_r + LVL_W'(1);
            ar_nxt    = {ar_r[CRD_W-2:0], NEAR_A_R[dir_r]};
            ac_nxt    = {ac_r[CRD_W-2:0], NEAR_A_C[dir_r]};
            br_nxt    = {ar_r[CRD_W-2:0], NEAR_B_R[dir_r]};
            bc_nxt    = {ac_r[CRD_W-2:0], NEAR_B_C[dir_r]};
            state_nxt = S_PAIR_A;
          end
        end else if (lvl_r == '0) begin
          res_nxt    = err_res();
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
          ar_nxt  = pa_row;
          ac_nxt  = pa_col;
        end
      end

      S_PAIR_A: begin
        a_used_nxt = used_bit;
        state_nxt  = S_PAIR_B;
      end

      S_PAIR_B: begin
        if (a_used_r && used_bit) begin
          if (deeper) begin
            lvl_nxt   = lvl_r + LVL_W'(1);
            ar_nxt    = {ar_r[CRD_W-2:0], NEAR_B_R[dir_r]};
            ac_nxt    = {ac_r[CRD_W-2:0], NEAR_B_C[dir_r]};
            br_nxt    = {br_r[CRD_W-2:0], NEAR_A_R[dir_r]};
            bc_nxt    = {bc_r[CRD_W-2:0], NEAR_A_C[dir_r]};
            state_nxt = S_PAIR_A;
          end else begin
            res_nxt    = mk_res(lvl_r, ar_r, ac_r, 1'b1, br_r, bc_r);
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (a_used_r) begin
          if (deeper) begin
            lvl_nxt   = lvl_r + LVL_W'(1);
            ar_nxt    = {ar_r[CRD_W-2:0], NEAR_B_R[dir_r]};
            ac_nxt    = {ac_r[CRD_W-2:0], NEAR_B_C[dir_r]};
            state_nxt = S_SING_A;
          end else begin
            res_nxt    = mk_res(lvl_r, ar_r, ac_r, 1'b0, '0, '0);
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (used_bit) begin
          if (deeper) begin
            lvl_nxt   = lvl_r + LVL_W'(1);
            br_nxt    = {br_r[CRD_W-2:0], NEAR_A_R[dir_r]};
            bc_nxt    = {bc_r[CRD_W-2:0], NEAR_A_C[dir_r]};
            state_nxt = S_SING_B;
          end else begin
            res_nxt    = mk_res(lvl_r, br_r, bc_r, 1'b0, '0, '0);
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          // Both children stop: return their parents, once if they coincide.
          res_nxt    = mk_res(lvl_r - LVL_W'(1), pa_row, pa_col,
                              (pa_row != pb_row) || (pa_col != pb_col), pb_row, pb_col);
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_SING_A: begin
        if (used_bit && deeper) begin
          lvl_nxt = lvl_r + LVL_W'(1);
          ar_nxt  = {ar_r[CRD_W-2:0], NEAR_B_R[dir_r]};
          ac_nxt  = {ac_r[CRD_W-2:0], NEAR_B_C[dir_r]};
        end else begin
          if (used_bit) begin
            res_nxt = mk_res(lvl_r, ar_r, ac_r, 1'b0, '0, '0);
          end else begin
            res_nxt = mk_res(lvl_r - LVL_W'(1), pa_row, pa_col, 1'b0, '0, '0);
          end
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_SING_B: begin
        if (used_bit && deeper) begin
          lvl_nxt = lvl_r + LVL_W'(1);
          br_nxt  = {br_r[CRD_W-2:0], NEAR_A_R[dir_r]};
          bc_nxt  = {bc_r[CRD_W-2:0], NEAR_A_C[dir_r]};
        end else begin
          if (used_bit) begin
            res_nxt = mk_res(lvl_r, br_r, bc_r, 1'b0, '0, '0);
          end else begin
            res_nxt = mk_res(lvl_r - LVL_W'(1), pb_row, pb_col, 1'b0, '0, '0);
          end
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The probe is addressed from the next-state values, so the read data of
  // the RAM belongs to the current registers in the following cycle.
  assign sel_b     = (state_nxt == S_PAIR_B) || (state_nxt == S_SING_B);
  assign probe.lvl = lvl_nxt;
  assign probe.row = sel_b ? br_nxt : ar_nxt;
  assign probe.col = sel_b ? bc_nxt : ac_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    d_r      <= d_nxt;
    tl_r     <= tl_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    dir_r    <= dir_nxt;
    lvl_r    <= lvl_nxt;
    ar_r     <= ar_nxt;
    ac_r     <= ac_nxt;
    br_r     <= br_nxt;
    bc_r     <= bc_nxt;
    a_used_r <= a_used_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign res_strobe = strobe_r;
  assign res        = res_r;

endmodule

// ===== hw/rtl/quadtree_face_neighbor_finder.sv =====
// ----------------------------------------------------------------------------
// Quadtree face neighbour finder
// Used-bit pyramid of a quadtree with a face neighbour search over it.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   input     start high, busy low       in_item  (qnf_in_t)
//   result    out_strobe, one cycle      out_item (qnf_out_t)
//
// A write transaction completes at its acceptance edge and gives no result.
// A query transaction gives one result. An error or an off-grid face is
// answered straight from the check state; otherwise the sequencer first
// walks the pyramid, one used-bit probe per cycle through the single read
// port of the pyramid RAM.
// After reset the pyramid is cleared, all (4^LEVELS - 1) / 3 bits (21845 at
// the default), one bit a cycle, and busy stays high until it is done.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "quadtree_face_neighbor_finder_defines.svh"

module quadtree_face_neighbor_finder #(
  parameter int LEVELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  qnf_pkg::qnf_in_t  in_item,
  output logic              out_strobe,
  output qnf_pkg::qnf_out_t out_item
);
  import qnf_pkg::*;

  // One bit for every cell of every level.
  localparam int DEPTH = ((1 << (2 * LEVELS)) - 1) / 3;
  localparam int AW    = $clog2(DEPTH);

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_act_r, clr_act_nxt;

  logic          accept;
  logic          wr_ok;
  logic          wr_en;
  logic [7:0]    in_size;
  logic          walk_busy;
  logic          walk_go;
  logic          used_bit;
  qnf_cell_t     probe;
  qnf_cell_t     addr_cell;
  logic [AW-1:0] cell_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;

  assign busy   = clr_act_r | walk_busy;
  assign accept = start & ~busy;

  // A write to a level or a cell outside the pyramid is dropped.
  assign in_size = 8'd1 << in_item.cell_level;
  assign wr_ok   = (32'(in_item.cell_level) < LEVELS) &&
                   ({1'b0, in_item.cell_row} < in_size) &&
                   ({1'b0, in_item.cell_col} < in_size);
  assign wr_en   = accept && (in_item.func == FUNC_WRITE) && wr_ok;
  assign walk_go = accept && (in_item.func == FUNC_QUERY);

  // Clearing sweep after reset; the block takes no transaction meanwhile.
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    clr_act_nxt = clr_act_r;
    if (clr_act_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      clr_act_r <= 1'b1;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      clr_act_r <= clr_act_nxt;
    end
  end

  // The address unit is shared: the sequencer's probe while a query runs,
  // otherwise the cell of the incoming write.
  always_comb begin
    if (walk_busy) begin
      addr_cell = probe;
    end else begin
      addr_cell.lvl = in_item.cell_level;
      addr_cell.row = in_item.cell_row;
      addr_cell.col = in_item.cell_col;
    end
  end

  qnf_addr #(
    .AW (AW)
  ) u_addr (
    .loc  (addr_cell),
    .addr (cell_addr)
  );

  assign ram_we    = clr_act_r | wr_en;
  assign ram_waddr = clr_act_r ? clr_cnt_r : cell_addr;
  assign ram_wdata = clr_act_r ? 1'b0 : in_item.used_value;

  qnf_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_pyramid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_addr),
    .rdata (used_bit)
  );

  qnf_walker #(
    .LEVELS (LEVELS)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (walk_go),
    .item       (in_item),
    .used_bit   (used_bit),
    .probe      (probe),
    .busy       (walk_busy),
    .res_strobe (out_strobe),
    .res        (out_item)
  );

  // A result never lasts beyond one cycle, since every query passes the
  // check state before it can answer.
  `QNF_ASSERT_NXT(a_strobe_single, out_strobe, !out_strobe)

  // An error result carries nothing else.
  `QNF_ASSERT_IMP(a_error_clean, out_strobe && out_item.request_error,
    out_item.found_level == '0 && out_item.first_row == '0 &&
    out_item.first_col == '0 && !out_item.second_valid)

  // The second cell reads as zero when it is not returned.
  `QNF_ASSERT_IMP(a_second_zero, out_strobe && !out_item.second_valid,
    out_item.second_row == '0 && out_item.second_col == '0)

  // A write transaction produces no result.
  `QNF_ASSERT_NXT(a_write_silent, accept && in_item.func == FUNC_WRITE, !out_strobe)

endmodule

// ===== bench/quadtree_face_neighbor_finder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadtree face neighbour finder testbench
// Walks a short table of hand-picked transactions and then a long stream of
// random ones through the finder, and checks every answer against a typed-in
// answer or a model of the used-bit pyramid kept inside the bench.
// ----------------------------------------------------------------------------
module quadtree_face_neighbor_finder_tb;
  import qnf_pkg::*;

  localparam int LEVELS       = 8;
  localparam int PYR_CELLS    = ((1 << (2 * LEVELS)) - 1) / 3;
  localparam int RANDOM_ITEMS = 1400;
  // The clearing pass after reset keeps busy high while it sweeps all PYR_CELLS
  // bits, so the limit on cycles without any transaction must leave room for it.
  localparam int IDLE_LIMIT   = 100000;
  localparam int TAIL_CYCLES  = 4 * LEVELS + 8;

  // request_error is the lowest bit of the result, every other field is zero.
  localparam qnf_out_t NO_ANSWER = qnf_out_t'(1);

  typedef enum logic [1:0] {
    DIR_ROW_INC,
    DIR_ROW_DEC,
    DIR_COL_INC,
    DIR_COL_DEC
  } face_dir_e;

  // One line of the directed table. Where known is set the answer is typed
  // in; elsewhere the pyramid model supplies it.
  typedef struct {
    qnf_in_t  item;
    bit       known;
    qnf_out_t answer;
  } stim_row_t;

  logic     clk;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  qnf_in_t  in_item = '0;
  logic     busy;
  logic     out_strobe;
  qnf_out_t out_item;

  bit        used_map [PYR_CELLS];
  qnf_out_t  awaited_answers [$];
  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  stim_row_t directed_rows [$];

  // The random part gathers its cells around a focus point so that used
  // bits pile up along chains of ancestors and children.
  int focus_row, focus_col;

  quadtree_face_neighbor_finder #(.LEVELS(LEVELS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the used-bit pyramid and of the neighbour search.
  // --------------------------------------------------------------------------

  function automatic int pyr_index(int lvl, int r, int c);
    return ((1 << (2 * lvl)) - 1) / 3 + (r << lvl) + c;
  endfunction

  function automatic bit is_used(int lvl, int r, int c);
    int ix;
    if (lvl >= LEVELS) return 1'b0;
    ix = pyr_index(lvl, r, c);
    if (ix >= PYR_CELLS) return 1'b0;
    return used_map[ix];
  endfunction

  // The second cell is forced to zero when it is not valid, as the block does.
  function automatic qnf_out_t make_answer(int lvl, int r1, int c1,
                                           bit two, int r2, int c2);
    qnf_out_t res;
    res               = '0;
    res.found_level   = lvl[LVL_W-1:0];
    res.first_row     = r1[CRD_W-1:0];
    res.first_col     = c1[CRD_W-1:0];
    res.second_valid  = two;
    res.second_row    = two ? r2[CRD_W-1:0] : '0;
    res.second_col    = two ? c2[CRD_W-1:0] : '0;
    return res;
  endfunction

  // Applies one transaction to the model. Returns 1 when it yields a result,
  // which is then left in res.
  function automatic bit find_neighbour(input qnf_in_t it, output qnf_out_t res);
    int lvl, tl, sz, ni, nj, ar, ac, br, bc;
    int a_r, a_c, b_r, b_c, fr, fc, f_r, f_c;
    bit a_on, b_on;
    res = NO_ANSWER;
    lvl = it.cell_level;
    sz  = 1 << lvl;
    if (it.func == FUNC_WRITE) begin
      if (lvl < LEVELS && it.cell_row < sz && it.cell_col < sz)
        used_map[pyr_index(lvl, it.cell_row, it.cell_col)] = it.used_value;
      return 1'b0;
    end
    tl = (it.target_level >= LEVELS) ? LEVELS - 1 : it.target_level;
    if (lvl >= LEVELS || it.cell_row >= sz || it.cell_col >= sz || tl < lvl)
      return 1'b1;

    // Neighbour cell, and the child corners of that cell which touch the
    // shared face (corner a, corner b).
    ni = it.cell_row;
    nj = it.cell_col;
    case (face_dir_e'(it.direction))
      DIR_ROW_INC: begin
        ni = ni + 1; a_r = 0; a_c = 0; b_r = 0; b_c = 1;
      end
      DIR_ROW_DEC: begin
        ni = ni - 1; a_r = 1; a_c = 0; b_r = 1; b_c = 1;
      end
      DIR_COL_INC: begin
        nj = nj + 1; a_r = 0; a_c = 0; b_r = 1; b_c = 0;
      end
      default: begin
        nj = nj - 1; a_r = 0; a_c = 1; b_r = 1; b_c = 1;
      end
    endcase

    // A face on the edge of the grid returns the cell itself.
    if (ni < 0 || nj < 0 || ni >= sz || nj >= sz) begin
      res = make_answer(lvl, it.cell_row, it.cell_col, 1'b0, 0, 0);
      return 1'b1;
    end

    // An unused neighbour gives way to its nearest used ancestor.
    if (!is_used(lvl, ni, nj)) begin
      while (!is_used(lvl, ni, nj)) begin
        if (lvl == 0) return 1'b1;
        ni  = ni >> 1;
        nj  = nj >> 1;
        lvl = lvl - 1;
      end
      res = make_answer(lvl, ni, nj, 1'b0, 0, 0);
      return 1'b1;
    end
    if (lvl == tl) begin
      res = make_answer(lvl, ni, nj, 1'b0, 0, 0);
      return 1'b1;
    end

    // Descend with both face corners for as long as both are used. Below the
    // first level, corner a goes on through the b offsets and the other way
    // round.
    lvl = lvl + 1;
    ar  = 2 * ni + a_r;
    ac  = 2 * nj + a_c;
    br  = 2 * ni + b_r;
    bc  = 2 * nj + b_c;
    while (lvl < tl && is_used(lvl, ar, ac) && is_used(lvl, br, bc)) begin
      lvl = lvl + 1;
      ar  = 2 * ar + b_r;
      ac  = 2 * ac + b_c;
      br  = 2 * br + a_r;
      bc  = 2 * bc + a_c;
    end
    a_on = is_used(lvl, ar, ac);
    b_on = is_used(lvl, br, bc);

    if (a_on && b_on) begin
      res = make_answer(lvl, ar, ac, 1'b1, br, bc);
    end else if (a_on || b_on) begin
      // Only one corner survives: follow it alone to its last used level.
      if (a_on) begin
        fr = ar; fc = ac; f_r = b_r; f_c = b_c;
      end else begin
        fr = br; fc = bc; f_r = a_r; f_c = a_c;
      end
      while (lvl < tl && is_used(lvl, fr, fc)) begin
        lvl = lvl + 1;
        fr  = 2 * fr + f_r;
        fc  = 2 * fc + f_c;
      end
      if (!is_used(lvl, fr, fc)) begin
        lvl = lvl - 1;
        fr  = fr >> 1;
        fc  = fc >> 1;
      end
      res = make_answer(lvl, fr, fc, 1'b0, 0, 0);
    end else begin
      // Both corners stopped: return their parents, once if they coincide.
      lvl = lvl - 1;
      ar  = ar >> 1;
      ac  = ac >> 1;
      br  = br >> 1;
      bc  = bc >> 1;
      res = make_answer(lvl, ar, ac, !(ar == br && ac == bc), br, bc);
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  function automatic qnf_in_t query(int lvl, int r, int c, face_dir_e dir, int tl);
    qnf_in_t it;
    it              = '0;
    it.func         = FUNC_QUERY;
    it.cell_level   = lvl[LVL_W-1:0];
    it.cell_row     = r[CRD_W-1:0];
    it.cell_col     = c[CRD_W-1:0];
    it.direction    = dir;
    it.target_level = tl[LVL_W-1:0];
    return it;
  endfunction

  function automatic qnf_in_t write_bit(int lvl, int r, int c, bit v);
    qnf_in_t it;
    it            = '0;
    it.func       = FUNC_WRITE;
    it.cell_level = lvl[LVL_W-1:0];
    it.cell_row   = r[CRD_W-1:0];
    it.cell_col   = c[CRD_W-1:0];
    it.used_value = v;
    return it;
  endfunction

  // Mostly well-formed transactions near the focus point; one in ten is pure
  // noise over every bit of every field, cells outside their level included.
  function automatic qnf_in_t random_item();
    qnf_in_t it;
    int lvl, r, c;
    if ($urandom_range(0, 9) == 0) begin
      it.func         = 1'($urandom);
      it.cell_level   = LVL_W'($urandom);
      it.cell_row     = CRD_W'($urandom);
      it.cell_col     = CRD_W'($urandom);
      it.direction    = 2'($urandom);
      it.target_level = LVL_W'($urandom);
      it.used_value   = 1'($urandom);
      return it;
    end
    lvl = $urandom_range(0, LEVELS - 1);
    r   = (focus_row >> (LEVELS - 1 - lvl)) + $urandom_range(0, 2) - 1;
    c   = (focus_col >> (LEVELS - 1 - lvl)) + $urandom_range(0, 2) - 1;
    if (r < 0) r = 0;
    if (c < 0) c = 0;
    if (r >= (1 << lvl)) r = (1 << lvl) - 1;
    if (c >= (1 << lvl)) c = (1 << lvl) - 1;
    if ($urandom_range(0, 99) < 45)
      return write_bit(lvl, r, c, $urandom_range(0, 3) != 0);
    // A few queries ask for a target above the cell on purpose.
    return query(lvl, r, c, face_dir_e'($urandom_range(0, 3)),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, LEVELS - 1)
                                             : $urandom_range(lvl, LEVELS - 1));
  endfunction

  // Offers one transaction and holds it until the block takes it. On the
  // accepting edge the model is updated and any answer is queued.
  task automatic send_item(input qnf_in_t it, input bit known, input qnf_out_t answer);
    qnf_out_t predicted;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (find_neighbour(it, predicted))
      awaited_answers.push_back(known ? answer : predicted);
  endtask

  // Both pauses lower start and then wait on the clock, so the next offer
  // never lands in the same time step as the lowering.
  task automatic hold_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_answers();
    start <= 1'b0;
    do @(posedge clk); while (awaited_answers.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result checking. The block cannot be held off, so every strobe is taken.
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    qnf_out_t want;
    if (rst_n && out_strobe) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch($sformatf("result %h with no transaction pending", out_item));
      end else begin
        want = awaited_answers.pop_front();
        check_field("found_level",   8'(out_item.found_level),   8'(want.found_level));
        check_field("first_row",     8'(out_item.first_row),     8'(want.first_row));
        check_field("first_col",     8'(out_item.first_col),     8'(want.first_col));
        check_field("second_valid",  8'(out_item.second_valid),  8'(want.second_valid));
        check_field("second_row",    8'(out_item.second_row),    8'(want.second_row));
        check_field("second_col",    8'(out_item.second_col),    8'(want.second_col));
        check_field("request_error", 8'(out_item.request_error), 8'(want.request_error));
      end
    end
  end

  // Watchdog: any accepted transaction on either side restarts the count.
  always @(posedge clk) begin
    if ((start && !busy && rst_n) || (out_strobe && rst_n)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------

  initial begin
    int burst_left;
    qnf_in_t it;

    // Directed table. The first group runs on an empty pyramid, so every
    // answer can be typed in; later rows lean on the model.
    directed_rows = '{
      // Root and the grid corners: the face lies off the grid.
      '{query(0, 0, 0, DIR_ROW_INC, 7), 1'b1, make_answer(0, 0, 0, 1'b0, 0, 0)},
      '{query(7, 127, 127, DIR_ROW_INC, 7), 1'b1, make_answer(7, 127, 127, 1'b0, 0, 0)},
      '{query(7, 0, 0, DIR_COL_DEC, 7), 1'b1, make_answer(7, 0, 0, 1'b0, 0, 0)},
      // Nothing used up to the root.
      '{query(3, 2, 2, DIR_COL_INC, 5), 1'b1, NO_ANSWER},
      // Target above the cell's own level.
      '{query(4, 1, 1, DIR_ROW_INC, 3), 1'b1, NO_ANSWER},
      // Row, then column, outside the cell's level.
      '{query(2, 4, 0, DIR_ROW_INC, 3), 1'b1, NO_ANSWER},
      '{query(1, 0, 2, DIR_ROW_DEC, 3), 1'b1, NO_ANSWER},
      '{write_bit(0, 0, 0, 1'b1), 1'b0, NO_ANSWER},
      // A write outside its level is dropped.
      '{write_bit(1, 3, 0, 1'b1), 1'b0, NO_ANSWER},
      // Climb all the way to the now used root.
      '{query(3, 2, 2, DIR_COL_DEC, 5), 1'b1, make_answer(0, 0, 0, 1'b0, 0, 0)},
      '{query(1, 0, 1, DIR_ROW_INC, 7), 1'b0, NO_ANSWER},
      '{write_bit(1, 1, 1, 1'b1), 1'b0, NO_ANSWER},
      '{write_bit(2, 2, 2, 1'b1), 1'b0, NO_ANSWER},
      '{write_bit(2, 2, 3, 1'b1), 1'b0, NO_ANSWER},
      '{write_bit(2, 3, 2, 1'b1), 1'b0, NO_ANSWER},
      // Both face corners used, for two directions.
      '{query(1, 0, 1, DIR_ROW_INC, 7), 1'b0, NO_ANSWER},
      '{query(1, 1, 0, DIR_COL_INC, 7), 1'b0, NO_ANSWER},
      // Target equal to the cell level stops at the neighbour.
      '{query(1, 1, 0, DIR_COL_INC, 1), 1'b0, NO_ANSWER},
      '{write_bit(3, 4, 4, 1'b1), 1'b0, NO_ANSWER},
      // One corner used: it is followed alone.
      '{query(2, 2, 1, DIR_COL_INC, 7), 1'b0, NO_ANSWER},
      '{write_bit(2, 2, 3, 1'b0), 1'b0, NO_ANSWER},
      '{query(1, 0, 1, DIR_ROW_INC, 7), 1'b0, NO_ANSWER},
      '{query(1, 0, 1, DIR_ROW_DEC, 2), 1'b1, make_answer(1, 0, 1, 1'b0, 0, 0)},
      '{query(2, 3, 3, DIR_ROW_DEC, 7), 1'b0, NO_ANSWER},
      // Used neighbour with no used children: returned once.
      '{query(2, 3, 1, DIR_COL_INC, 7), 1'b0, NO_ANSWER}
    };

    // Synchronous reset, once, then the block clears its pyramid with busy
    // held high; the first offer simply waits for that to finish.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].answer);

    // Let the block drain completely before the random stream.
    wait_for_answers();

    // Random stream in bursts. Some bursts follow on without a gap, others
    // start after a pause of random length; now and then the sender waits
    // until every answer has arrived.
    burst_left = 0;
    focus_row  = $urandom_range(0, 127);
    focus_col  = $urandom_range(0, 127);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) == 0) begin
          focus_row = $urandom_range(0, 127);
          focus_col = $urandom_range(0, 127);
        end
        if ($urandom_range(0, 2) != 0)
          hold_sender($urandom_range(1, 12));
      end
      it = random_item();
      send_item(it, 1'b0, NO_ANSWER);
      burst_left--;
      if (n % 350 == 349)
        wait_for_answers();
    end

    wait_for_answers();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
